FILE: hw/rtl/ptd_pkg.sv
// Shared types and constants for the periodic task dispatcher.
// No dependencies; used by periodic_task_dispatcher and ptd_out_reg.
`default_nettype none

package ptd_pkg;

    localparam int MAX_TASKS = 32;
    localparam int ADDR_W    = $clog2(MAX_TASKS);
    // entries the scan may cover at most
    localparam int SCAN_CAP  = (MAX_TASKS < 32) ? MAX_TASKS : 32;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_DONE  = 2'd2,
        ACT_WRITE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_DISPATCH = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_ACCEPT   = 2'd2,
        KIND_REJECT   = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_DONE_RD = 4'b0010,
        ST_SCAN    = 4'b0100,
        ST_PUSH    = 4'b1000
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [4:0]  task_id;
        logic        slipped;
        logic        overran;
        logic [15:0] tick_count;
        logic [31:0] spare_us_total;
        logic [4:0]  spare_run_count;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/ptd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ptd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/ptd_out_reg.sv
// Output word register: holds one result word until the receiver takes it.
// Depends on ptd_pkg.
`default_nettype none

module ptd_out_reg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire ptd_pkg::t_result i_res,
    input  wire logic             i_stall,
    output      logic             o_valid,
    output      logic             o_free,
    output      ptd_pkg::t_result o_res
);

    logic             r_valid;
    logic             n_valid;
    ptd_pkg::t_result r_res;

    // free when empty or the held word leaves this cycle
    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (o_free) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

FILE: hw/rtl/periodic_task_dispatcher.sv
// Periodic task dispatcher: one item in, one result word out, one item at a time.
// A tick, table write or rejected item goes straight to ST_PUSH; a task-done item whose time
// runs out passes through ST_DONE_RD first. A start item runs ST_SCAN, and a done item that
// resumes the scan runs ST_DONE_RD and then ST_SCAN from the entry after the dispatched task;
// the scan checks at most task_count entries, capped at 32. The task table and last-run
// memories are read one entry per cycle and each entry is checked in the cycle after its
// read. A stalled output register holds the dispatcher in ST_PUSH. A result word waits in
// the output register while the next item is taken. Task intervals and budgets must be
// written before a run scans them.
// Depends on ptd_pkg, ptd_ram and ptd_out_reg.
`default_nettype none

module periodic_task_dispatcher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration: task_count
    input  wire logic        i_cfg_we,
    input  wire logic [5:0]  i_cfg_wdata,
    // input words
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [15:0] i_budget_us,
    input  wire logic [31:0] i_elapsed_us,
    input  wire logic [4:0]  i_entry_index,
    input  wire logic [15:0] i_entry_interval,
    input  wire logic [15:0] i_entry_budget_us,
    // result words
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      logic [1:0]  o_result_kind,
    output      logic [4:0]  o_task_id,
    output      logic        o_slipped,
    output      logic        o_overran,
    output      logic [15:0] o_tick_count,
    output      logic [31:0] o_spare_us_total,
    output      logic [4:0]  o_spare_run_count
);

    localparam int AW = ptd_pkg::ADDR_W;

    ptd_pkg::t_state r_state, n_state;
    logic [15:0] r_tick, n_tick;
    logic [5:0]  r_task_count;
    logic [15:0] r_remaining, n_remaining;
    logic [AW-1:0] r_cursor, n_cursor;
    logic        r_run_active, n_run_active;
    logic [31:0] r_spare, n_spare;
    logic [4:0]  r_runs, n_runs;
    logic [31:0] r_el, n_el;
    logic [5:0]  r_rd_idx, n_rd_idx;
    logic        r_chk_vld, n_chk_vld;
    logic [AW-1:0] r_chk_idx, n_chk_idx;
    logic [ptd_pkg::MAX_TASKS-1:0] r_lr_vld, n_lr_vld;
    ptd_pkg::t_kind r_res_kind, n_res_kind;
    logic [4:0]  r_res_id, n_res_id;
    logic        r_res_slip, n_res_slip;
    logic        r_res_over, n_res_over;

    logic        w_accept;
    logic        w_out_free;
    logic        w_push;
    ptd_pkg::t_result w_res, w_out_res;
    logic [5:0]  w_lim;
    logic [AW-1:0] w_raddr;
    logic        w_tb_we;
    logic [31:0] w_tb_rdata;
    logic        w_lr_we;
    logic [15:0] w_lr_rdata;
    logic [15:0] w_last, w_dt, w_twice, w_iv, w_bud;
    logic        w_hit;
    logic        w_fin_add;
    logic [31:0] w_fin_sum;
    logic [5:0]  w_runs_inc;
    logic [31:0] w_fin_spare;
    logic [4:0]  w_fin_runs;

    assign o_in_stall = (r_state != ptd_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_lim = (r_task_count > 6'(ptd_pkg::SCAN_CAP)) ? 6'(ptd_pkg::SCAN_CAP)
                                                          : r_task_count;

    // done reads the in-flight task's entry; the scan reads the issue index
    assign w_raddr = (r_state == ptd_pkg::ST_SCAN) ? r_rd_idx[AW-1:0] : r_cursor;

    assign w_tb_we = w_accept && (i_action == ptd_pkg::ACT_WRITE) && !r_run_active
                     && ({1'b0, i_entry_index} < 6'(ptd_pkg::MAX_TASKS));
    assign w_lr_we = w_accept && (i_action == ptd_pkg::ACT_DONE) && r_run_active;

    ptd_ram #(.WIDTH(32), .DEPTH(ptd_pkg::MAX_TASKS)) u_task_ram (
        .i_clk   (i_clk),
        .i_we    (w_tb_we),
        .i_waddr (i_entry_index[AW-1:0]),
        .i_wdata ({i_entry_interval, i_entry_budget_us}),
        .i_raddr (w_raddr),
        .o_rdata (w_tb_rdata)
    );

    ptd_ram #(.WIDTH(16), .DEPTH(ptd_pkg::MAX_TASKS)) u_last_ram (
        .i_clk   (i_clk),
        .i_we    (w_lr_we),
        .i_waddr (r_cursor),
        .i_wdata (r_tick),
        .i_raddr (w_raddr),
        .o_rdata (w_lr_rdata)
    );

    assign w_iv    = w_tb_rdata[31:16];
    assign w_bud   = w_tb_rdata[15:0];
    // a last-run entry never written since reset reads as zero
    assign w_last  = r_lr_vld[r_chk_idx] ? w_lr_rdata : 16'd0;
    assign w_dt    = r_tick - w_last;
    assign w_twice = {w_iv[14:0], 1'b0};
    assign w_hit   = r_chk_vld && (w_dt >= w_iv) && (w_bud <= r_remaining);

    // end of run: spare time only when the scan ran out of entries
    assign w_fin_add   = (r_state == ptd_pkg::ST_SCAN);
    assign w_fin_sum   = r_spare + (w_fin_add ? {16'd0, r_remaining} : 32'd0);
    assign w_runs_inc  = {1'b0, r_runs} + 6'd1;
    assign w_fin_spare = (w_runs_inc >= 6'd32) ? {1'b0, w_fin_sum[31:1]} : w_fin_sum;
    assign w_fin_runs  = (w_runs_inc >= 6'd32) ? 5'd16 : w_runs_inc[4:0];

    always_comb begin
        n_state      = r_state;
        n_tick       = r_tick;
        n_remaining  = r_remaining;
        n_cursor     = r_cursor;
        n_run_active = r_run_active;
        n_spare      = r_spare;
        n_runs       = r_runs;
        n_el         = r_el;
        n_rd_idx     = r_rd_idx;
        n_chk_vld    = r_chk_vld;
        n_chk_idx    = r_chk_idx;
        n_lr_vld     = r_lr_vld;
        n_res_kind   = r_res_kind;
        n_res_id     = r_res_id;
        n_res_slip   = r_res_slip;
        n_res_over   = r_res_over;
        w_push       = 1'b0;

        case (r_state)
            ptd_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_res_kind = ptd_pkg::KIND_ACCEPT;
                    n_res_id   = 5'd0;
                    n_res_slip = 1'b0;
                    n_res_over = 1'b0;
                    n_state    = ptd_pkg::ST_PUSH;
                    case (i_action)
                        ptd_pkg::ACT_TICK: begin
                            n_tick = r_tick + 16'd1;
                        end
                        ptd_pkg::ACT_START: begin
                            if (r_run_active) begin
                                n_res_kind = ptd_pkg::KIND_REJECT;
                            end else begin
                                n_run_active = 1'b1;
                                n_remaining  = i_budget_us;
                                n_cursor     = '0;
                                n_rd_idx     = 6'd0;
                                n_chk_vld    = 1'b0;
                                n_state      = ptd_pkg::ST_SCAN;
                            end
                        end
                        ptd_pkg::ACT_DONE: begin
                            if (!r_run_active) begin
                                n_res_kind = ptd_pkg::KIND_REJECT;
                            end else begin
                                n_el               = i_elapsed_us;
                                n_lr_vld[r_cursor] = 1'b1;
                                n_state            = ptd_pkg::ST_DONE_RD;
                            end
                        end
                        default: begin
                            if (r_run_active) begin
                                n_res_kind = ptd_pkg::KIND_REJECT;
                            end
                        end
                    endcase
                end
            end
            ptd_pkg::ST_DONE_RD: begin
                n_res_over = (r_el > {16'd0, w_bud});
                if (r_el >= {16'd0, r_remaining}) begin
                    n_spare      = w_fin_spare;
                    n_runs       = w_fin_runs;
                    n_run_active = 1'b0;
                    n_res_kind   = ptd_pkg::KIND_COMPLETE;
                    n_state      = ptd_pkg::ST_PUSH;
                end else begin
                    n_remaining = r_remaining - r_el[15:0];
                    n_rd_idx    = {1'b0, r_cursor} + 6'd1;
                    n_chk_vld   = 1'b0;
                    n_state     = ptd_pkg::ST_SCAN;
                end
            end
            ptd_pkg::ST_SCAN: begin
                if (w_hit) begin
                    n_cursor   = r_chk_idx;
                    n_res_kind = ptd_pkg::KIND_DISPATCH;
                    n_res_id   = 5'(r_chk_idx);
                    n_res_slip = (w_dt >= w_twice);
                    n_chk_vld  = 1'b0;
                    n_state    = ptd_pkg::ST_PUSH;
                end else if (!r_chk_vld && (r_rd_idx >= w_lim)) begin
                    n_spare      = w_fin_spare;
                    n_runs       = w_fin_runs;
                    n_run_active = 1'b0;
                    n_res_kind   = ptd_pkg::KIND_COMPLETE;
                    n_state      = ptd_pkg::ST_PUSH;
                end else if (r_rd_idx < w_lim) begin
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_rd_idx[AW-1:0];
                    n_rd_idx  = r_rd_idx + 6'd1;
                end else begin
                    n_chk_vld = 1'b0;
                end
            end
            ptd_pkg::ST_PUSH: begin
                if (w_out_free) begin
                    w_push  = 1'b1;
                    n_state = ptd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ptd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ptd_pkg::ST_IDLE;
            r_tick       <= 16'd0;
            r_task_count <= 6'd0;
            r_remaining  <= 16'd0;
            r_cursor     <= '0;
            r_run_active <= 1'b0;
            r_spare      <= 32'd0;
            r_runs       <= 5'd0;
            r_rd_idx     <= 6'd0;
            r_chk_vld    <= 1'b0;
            r_lr_vld     <= '0;
        end else begin
            r_state      <= n_state;
            r_tick       <= n_tick;
            r_remaining  <= n_remaining;
            r_cursor     <= n_cursor;
            r_run_active <= n_run_active;
            r_spare      <= n_spare;
            r_runs       <= n_runs;
            r_rd_idx     <= n_rd_idx;
            r_chk_vld    <= n_chk_vld;
            r_lr_vld     <= n_lr_vld;
            if (i_cfg_we) begin
                r_task_count <= i_cfg_wdata;
            end
        end
        r_el       <= n_el;
        r_chk_idx  <= n_chk_idx;
        r_res_kind <= n_res_kind;
        r_res_id   <= n_res_id;
        r_res_slip <= n_res_slip;
        r_res_over <= n_res_over;
    end

    assign w_res.kind            = r_res_kind;
    assign w_res.task_id         = r_res_id;
    assign w_res.slipped         = r_res_slip;
    assign w_res.overran         = r_res_over;
    assign w_res.tick_count      = r_tick;
    assign w_res.spare_us_total  = r_spare;
    assign w_res.spare_run_count = r_runs;

    ptd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_push),
        .i_res   (w_res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_free  (w_out_free),
        .o_res   (w_out_res)
    );

    assign o_result_kind     = w_out_res.kind;
    assign o_task_id         = w_out_res.task_id;
    assign o_slipped         = w_out_res.slipped;
    assign o_overran         = w_out_res.overran;
    assign o_tick_count      = w_out_res.tick_count;
    assign o_spare_us_total  = w_out_res.spare_us_total;
    assign o_spare_run_count = w_out_res.spare_run_count;

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("second word taken before the first finished");

    a_scan_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ptd_pkg::ST_SCAN || r_state == ptd_pkg::ST_DONE_RD) |-> r_run_active)
        else $error("scan or done handling outside a run");

    a_push_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ptd_pkg::ST_PUSH && w_out_free) |=> (r_state == ptd_pkg::ST_IDLE
                                                          && o_out_valid))
        else $error("result word not delivered to output register");

    a_chk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ptd_pkg::ST_SCAN && r_chk_vld) |-> ({1'b0, r_chk_idx} < w_lim))
        else $error("scan checked an entry beyond the task count");
`endif

endmodule

`default_nettype wire
